[rtl/bsfl_pkg.sv]
// ----------------------------------------------------------------------------
// Byte-set search package
// Shared types and constants for the byte-set first/last search block.
// ----------------------------------------------------------------------------
package bsfl_pkg;

  localparam int CHUNK_BYTES = 16;
  localparam int SET_SIZE    = 256;
  localparam int CFG_W       = 64;
  localparam int CFG_IDX_W   = 3;
  localparam int CNT_W       = 5;
  localparam int POS_W       = 16;
  localparam int OFF_W       = 17;
  localparam int POS_SPAN    = 65536;

  localparam int              LANES_DEF   = 16;
  localparam longint unsigned MAX_LEN_DEF = 64'd65536;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SET_0_63    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SET_64_127  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SET_128_191 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SET_192_255 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FROM_END    = 3'd5;

  typedef struct packed {
    logic [63:0]      chunk_low;
    logic [63:0]      chunk_high;
    logic [CNT_W-1:0] valid_bytes;
    logic             end_of_string;
  } chunk_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
    logic             overflow;
  } result_t;

endpackage

[rtl/bsfl_lane.sv]
// ----------------------------------------------------------------------------
// Byte-set search lane
// Looks one chunk byte up in the 256-entry set and flags a qualifying byte.
// ----------------------------------------------------------------------------
module bsfl_lane import bsfl_pkg::*; #(
  parameter int LANE_ID = 0
) (
  input  logic [7:0]          data_byte,
  input  logic [CNT_W-1:0]    count,
  input  logic [SET_SIZE-1:0] set_bits,
  input  logic                invert,
  output logic                hit
);

  logic in_chunk;
  logic member;

  assign in_chunk = CNT_W'(LANE_ID) < count;
  assign member   = set_bits[data_byte];
  assign hit      = in_chunk && (member ^ invert);

endmodule

[rtl/bsfl_merge.sv]
// ----------------------------------------------------------------------------
// Byte-set search merge
// Picks the lowest or highest lane hit, tracks the string offset and the
// candidate hit, and emits one result on the final chunk of a string.
// ----------------------------------------------------------------------------
module bsfl_merge import bsfl_pkg::*; #(
  parameter int               ACT   = 16,
  parameter logic [OFF_W-1:0] LIMIT = 17'd65536
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  logic [ACT-1:0]   hits,
  input  logic [CNT_W-1:0] count,
  input  logic             last,
  input  logic             from_end,
  output logic             res_fire,
  output result_t          res
);

  localparam int LIDX_W = (ACT > 1) ? $clog2(ACT) : 1;

  logic [OFF_W-1:0] string_offset, string_offset_next;
  logic             hit_seen, hit_seen_next;
  logic [POS_W-1:0] hit_position, hit_position_next;
  logic             length_exceeded, length_exceeded_next;

  logic [OFF_W-1:0]  room;
  logic [ACT-1:0]    masked;
  logic              over;
  logic              any_hit;
  logic [LIDX_W-1:0] low_idx;
  logic [LIDX_W-1:0] high_idx;
  logic [POS_W-1:0]  hit_pos;

  assign room = LIMIT - string_offset;
  assign over = OFF_W'(count) > room;

  always_comb begin
    for (int i = 0; i < ACT; i++) begin
      masked[i] = hits[i] && (OFF_W'(i) < room);
    end
  end

  // Priority encode both ends of the hit vector
  always_comb begin
    low_idx  = '0;
    high_idx = '0;
    for (int i = ACT - 1; i >= 0; i--) begin
      if (masked[i]) begin
        low_idx = LIDX_W'(i);
      end
    end
    for (int i = 0; i < ACT; i++) begin
      if (masked[i]) begin
        high_idx = LIDX_W'(i);
      end
    end
  end

  assign any_hit = |masked;
  assign hit_pos = string_offset[POS_W-1:0] +
                   POS_W'(from_end ? high_idx : low_idx);

  always_comb begin
    string_offset_next   = over ? LIMIT : string_offset + OFF_W'(count);
    length_exceeded_next = length_exceeded || over;
    hit_seen_next        = hit_seen;
    hit_position_next    = hit_position;
    if (any_hit && (from_end || !hit_seen)) begin
      hit_seen_next     = 1'b1;
      hit_position_next = hit_pos;
    end
  end

  assign res_fire     = advance && last;
  assign res.found    = hit_seen_next;
  assign res.position = hit_seen_next ? hit_position_next : '0;
  assign res.overflow = length_exceeded_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      string_offset   <= '0;
      hit_seen        <= 1'b0;
      hit_position    <= '0;
      length_exceeded <= 1'b0;
    end else if (advance) begin
      if (last) begin
        // drop per-string state once the result is out
        string_offset   <= '0;
        hit_seen        <= 1'b0;
        hit_position    <= '0;
        length_exceeded <= 1'b0;
      end else begin
        string_offset   <= string_offset_next;
        hit_seen        <= hit_seen_next;
        hit_position    <= hit_position_next;
        length_exceeded <= length_exceeded_next;
      end
    end
  end

endmodule

[rtl/byte_set_first_last_search.sv]
// ----------------------------------------------------------------------------
// Byte-set first/last search
// Finds the first or last byte of a chunked string that is in (or not in)
// a programmable 256-entry byte set.
// ----------------------------------------------------------------------------
// Usage:
//   Program the set with four 64-bit writes on cfg_we/cfg_index/cfg_data,
//   plus the invert and search-from-end flags, while the block is idle.
//   Feed the string as chunks of up to 16 bytes on chunk_valid/chunk_ready;
//   end_of_string marks the final chunk. One result item per string leaves
//   on result_valid/result_ready.
// Throughput: one chunk per cycle while chunk_ready is high. All lanes look
//   up their bytes in parallel; the merge stage updates the running offset
//   and candidate hit combinationally, so a new chunk enters as each advances.
// Result path: a final chunk is held in the lane register, then merged into
//   the output register, which raises result_valid.
// Stall: chunks that do not end a string keep flowing while a result waits.
//   A final chunk waits in the lane register until the output register is
//   free, and chunk_ready drops behind it.
// Reset: rst (synchronous) clears the set, both flags, the string state and
//   all valid flags; the block is ready in the cycle after reset.
// ----------------------------------------------------------------------------
module byte_set_first_last_search import bsfl_pkg::*; #(
  parameter int              LANES   = LANES_DEF,
  parameter longint unsigned MAX_LEN = MAX_LEN_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 chunk_valid,
  output logic                 chunk_ready,
  input  chunk_t               chunk,
  output logic                 result_valid,
  input  logic                 result_ready,
  output result_t              result
);

  localparam int ACT = (LANES < CHUNK_BYTES) ? LANES : CHUNK_BYTES;
  localparam logic [OFF_W-1:0] LIMIT =
      (MAX_LEN < longint'(POS_SPAN)) ? OFF_W'(MAX_LEN) : OFF_W'(POS_SPAN);

  logic [SET_SIZE-1:0] set_bits;
  logic                invert_match;
  logic                search_from_end;

  logic [8*CHUNK_BYTES-1:0] bytes;
  logic [CNT_W-1:0]         cnt_in;
  logic [ACT-1:0]           lane_hit;

  logic             a_valid;
  logic [ACT-1:0]   a_hits;
  logic [CNT_W-1:0] a_count;
  logic             a_last;
  logic             a_advance;

  logic    res_fire;
  result_t res;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      set_bits        <= '0;
      invert_match    <= 1'b0;
      search_from_end <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SET_0_63:    set_bits[63:0]    <= cfg_data;
        REG_SET_64_127:  set_bits[127:64]  <= cfg_data;
        REG_SET_128_191: set_bits[191:128] <= cfg_data;
        REG_SET_192_255: set_bits[255:192] <= cfg_data;
        REG_INVERT:      invert_match      <= cfg_data[0];
        REG_FROM_END:    search_from_end   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign bytes = {chunk.chunk_high, chunk.chunk_low};

  // Clamp the valid count to the chunk size and the lane count
  always_comb begin
    cnt_in = chunk.valid_bytes;
    if (cnt_in > CNT_W'(CHUNK_BYTES)) begin
      cnt_in = CNT_W'(CHUNK_BYTES);
    end
    if (cnt_in > CNT_W'(ACT)) begin
      cnt_in = CNT_W'(ACT);
    end
  end

  for (genvar g = 0; g < ACT; g++) begin : g_lane
    bsfl_lane #(
      .LANE_ID (g)
    ) u_lane (
      .data_byte (bytes[8*g +: 8]),
      .count     (cnt_in),
      .set_bits  (set_bits),
      .invert    (invert_match),
      .hit       (lane_hit[g])
    );
  end

  // A final chunk needs a free output slot to advance
  assign a_advance   = a_valid && (!a_last || !result_valid || result_ready);
  assign chunk_ready = !a_valid || a_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (chunk_ready) begin
      a_valid <= chunk_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (chunk_ready && chunk_valid) begin
      a_hits  <= lane_hit;
      a_count <= cnt_in;
      a_last  <= chunk.end_of_string;
    end
  end

  bsfl_merge #(
    .ACT   (ACT),
    .LIMIT (LIMIT)
  ) u_merge (
    .clk      (clk),
    .rst      (rst),
    .advance  (a_advance),
    .hits     (a_hits),
    .count    (a_count),
    .last     (a_last),
    .from_end (search_from_end),
    .res_fire (res_fire),
    .res      (res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res_fire) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_fire) begin
      result <= res;
    end
  end

endmodule
